// File: sv/gps_pkg.sv
// ----------------------------------------------------------------------------
// gps_pkg: shared types and constants of the gbm path step block
// widths, register indexes, fixed-point constants, sequencer states
// ----------------------------------------------------------------------------
package gps_pkg;

    // field widths
    localparam int PRICE_W    = 32;
    localparam int DRIFT_W    = 32;
    localparam int DIFF_W     = 31;
    localparam int SPP_W      = 13;
    localparam int Z_W        = 16;
    localparam int STEP_IDX_W = 13;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_START_PRICE = 2'd0,
        REG_DRIFT       = 2'd1,
        REG_DIFFUSION   = 2'd2,
        REG_STEPS       = 2'd3
    } cfg_reg_t;

    localparam logic [PRICE_W-1:0] START_PRICE_RST = 32'd6553600;  // 100.0
    localparam logic [SPP_W-1:0]   SPP_RST         = 13'd252;
    localparam int                 MAX_STEPS_DEF   = 4096;
    localparam int                 SPP_MAX         = 2**SPP_W - 1;

    // exp unit constants
    localparam logic [63:0] LN2_Q59   = 64'h058B90BFBE8E7BCD;
    localparam int          RED_BIAS  = 12;   // k offset so the reduction stays unsigned
    localparam int          RED_BITS  = 5;    // quotient bits of the range reduction
    localparam logic [63:0] LN2_X12   = LN2_Q59 * 64'(RED_BIAS);
    localparam logic [63:0] ONE_Q62   = 64'h4000000000000000;
    localparam int          TERMS_MAX = 40;
    localparam int          TERM_N_W  = 6;
    localparam int          EXP_SH_BASE = 38 + RED_BIAS;

    // shared multiplier and term divider
    localparam int MUL_W    = 33;
    localparam int DIV_STEP = 4;

    typedef struct packed {
        logic [DRIFT_W-1:0] drift;      // signed q4.28
        logic [DIFF_W-1:0]  diffusion;  // unsigned q3.28
    } gps_coef_t;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               ovf;
    } gps_res_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } gps_seq_st_t;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_EMUL = 10'b0000000010,
        S_ELOG = 10'b0000000100,
        S_RED  = 10'b0000001000,
        S_TMUL = 10'b0000010000,
        S_TDIV = 10'b0000100000,
        S_EXP  = 10'b0001000000,
        S_PMUL = 10'b0010000000,
        S_PRND = 10'b0100000000,
        S_SPARE = 10'b1000000000
    } gps_state_t;

    // ln2 in q59 shifted by a quotient bit position
    function automatic logic [63:0] ln2_shl(input logic [2:0] b);
        return LN2_Q59 << b;
    endfunction

endpackage

// File: sv/gps_mul.sv
// ----------------------------------------------------------------------------
// gps_mul: shared signed multiplier with registered product
// serves the diffusion term, the series partial products and the price update
// ----------------------------------------------------------------------------
module gps_mul import gps_pkg::*; #(
    parameter int W = MUL_W
) (
    input  logic                  aclk,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);

    logic signed [2*W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// File: sv/gps_div.sv
// ----------------------------------------------------------------------------
// gps_div: iterative restoring divider of a wide word by a small divisor
// STEP quotient bits per cycle, done is registered and pulses in the cycle after the last step
// ----------------------------------------------------------------------------
module gps_div import gps_pkg::*; #(
    parameter int W    = 64,
    parameter int DW   = TERM_N_W,
    parameter int STEP = DIV_STEP
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [W-1:0]  dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [W-1:0]  quotient
);

    localparam int ITER = W / STEP;
    localparam int CW   = (ITER > 1) ? $clog2(ITER) : 1;

    logic [W-1:0]  quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            for (int i = 0; i < STEP; i++) begin
                trial    = {rem_next, quo_next[W-1]};
                quo_next = {quo_next[W-2:0], 1'b0};
                if (trial >= {1'b0, divisor}) begin
                    rem_next    = DW'(trial - {1'b0, divisor});
                    quo_next[0] = 1'b1;
                end else begin
                    rem_next = trial[DW-1:0];
                end
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(ITER - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/gps_seq.sv
// ----------------------------------------------------------------------------
// gps_seq: step sequencer around the shared multiplier
// log increment, exp range reduction, taylor series, price product
// ----------------------------------------------------------------------------
module gps_seq import gps_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      go,
    input  logic signed [Z_W-1:0]     z,
    input  logic [PRICE_W-1:0]        price_in,
    input  gps_coef_t                 coef,
    input  logic                      out_hold,
    output gps_seq_st_t               st,
    output gps_res_t                  res
);

    gps_state_t state_reg, state_next;

    logic signed [Z_W-1:0]  z_reg, z_next;
    logic [PRICE_W-1:0]     price_reg, price_next;
    logic [63:0]            y_reg, y_next;
    logic [RED_BITS-1:0]    kp_reg, kp_next;
    logic [2:0]             red_cnt_reg, red_cnt_next;
    logic [63:0]            r_reg, r_next;
    logic [63:0]            term_reg, term_next;
    logic [63:0]            sum_reg, sum_next;
    logic [TERM_N_W-1:0]    n_reg, n_next;
    logic [2:0]             pp_reg, pp_next;
    logic [127:0]           acc_reg, acc_next;
    logic [31:0]            ex_reg, ex_next;

    // shared multiplier
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;

    // divider
    logic        div_start, div_done;
    logic [63:0] div_q;

    // log increment
    logic [47:0] p48;
    logic [48:0] p_rnd;
    logic [36:0] q37;
    logic [37:0] e_full;
    logic [31:0] e_sat;
    logic [63:0] y_calc;

    // range reduction
    logic [63:0] red_cmp;
    logic        red_ge;
    logic [63:0] y_sub;

    // series partial products
    logic [1:0]   pp_prev;
    logic [127:0] acc_add;

    // exp rounding
    logic [5:0]  sh;
    logic [64:0] ex_rnd;
    logic [64:0] ex_shr;
    logic [31:0] ex_calc;

    // price rounding
    logic [64:0] pr_rnd;
    logic [40:0] pr_q;

    gps_mul #(.W(MUL_W)) u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    gps_div #(.W(64), .DW(TERM_N_W), .STEP(DIV_STEP)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_next[125:62]),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // operand select: al/ah from the term, bl/bh from r
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg) inside
            S_EMUL: begin
                mul_a = {2'b00, coef.diffusion};
                mul_b = {{(MUL_W-Z_W){z_reg[Z_W-1]}}, z_reg};
            end
            S_TMUL: begin
                mul_a = {1'b0, (pp_reg[1] ? term_reg[63:32] : term_reg[31:0])};
                mul_b = {1'b0, (pp_reg[0] ? r_reg[63:32] : r_reg[31:0])};
            end
            S_PMUL, S_PRND: begin
                mul_a = {1'b0, price_reg};
                mul_b = {1'b0, ex_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // e = drift + round(diffusion*z), saturated, then biased into q59
    always_comb begin
        p48    = mul_p[47:0];
        p_rnd  = {p48[47], p48} + 49'd2048;
        q37    = p_rnd[48:12];
        e_full = {{6{coef.drift[31]}}, coef.drift} + {q37[36], q37};
        if (e_full[37:31] == {7{e_full[37]}}) begin
            e_sat = e_full[31:0];
        end else if (e_full[37]) begin
            e_sat = 32'h80000000;
        end else begin
            e_sat = 32'h7FFFFFFF;
        end
        y_calc = {e_sat[31], e_sat, 31'd0} + LN2_X12;
    end

    // one quotient bit of floor(y / ln2) per cycle
    always_comb begin
        red_cmp = ln2_shl(red_cnt_reg);
        red_ge  = (y_reg >= red_cmp);
        y_sub   = red_ge ? (y_reg - red_cmp) : y_reg;
    end

    always_comb begin
        pp_prev = 2'(pp_reg - 3'd1);
        case (pp_prev) inside
            2'd0:       acc_add = {64'd0, mul_p[63:0]};
            2'd1, 2'd2: acc_add = {32'd0, mul_p[63:0], 32'd0};
            default:    acc_add = {mul_p[63:0], 64'd0};
        endcase
    end

    // 2^k * sum rounded to q8.24, clamped
    always_comb begin
        sh      = 6'(EXP_SH_BASE) - {1'b0, kp_reg};
        ex_rnd  = {1'b0, sum_reg} + (65'd1 << (sh - 6'd1));
        ex_shr  = ex_rnd >> sh;
        ex_calc = (|ex_shr[64:32]) ? 32'hFFFFFFFF : ex_shr[31:0];
    end

    always_comb begin
        pr_rnd    = {1'b0, mul_p[63:0]} + 65'h800000;
        pr_q      = pr_rnd[64:24];
        res.ovf   = |pr_q[40:32];
        res.price = res.ovf ? 32'hFFFFFFFF : pr_q[31:0];
    end

    assign div_start = (state_reg == S_TMUL) && (pp_reg == 3'd4);

    always_comb begin
        state_next   = state_reg;
        z_next       = z_reg;
        price_next   = price_reg;
        y_next       = y_reg;
        kp_next      = kp_reg;
        red_cnt_next = red_cnt_reg;
        r_next       = r_reg;
        term_next    = term_reg;
        sum_next     = sum_reg;
        n_next       = n_reg;
        pp_next      = pp_reg;
        acc_next     = acc_reg;
        ex_next      = ex_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (go) begin
                    z_next     = z;
                    price_next = price_in;
                    state_next = S_EMUL;
                end
            end
            S_EMUL: begin
                state_next = S_ELOG;
            end
            S_ELOG: begin
                y_next       = y_calc;
                kp_next      = '0;
                red_cnt_next = 3'(RED_BITS - 1);
                state_next   = S_RED;
            end
            S_RED: begin
                y_next = y_sub;
                if (red_ge) begin
                    kp_next = kp_reg | (RED_BITS'(1) << red_cnt_reg);
                end
                if (red_cnt_reg == 3'd0) begin
                    r_next     = y_sub << 3;
                    term_next  = ONE_Q62;
                    sum_next   = ONE_Q62;
                    n_next     = TERM_N_W'(1);
                    pp_next    = '0;
                    acc_next   = '0;
                    state_next = S_TMUL;
                end else begin
                    red_cnt_next = red_cnt_reg - 3'd1;
                end
            end
            S_TMUL: begin
                if (pp_reg != 3'd0) begin
                    acc_next = acc_reg + acc_add;
                end
                if (pp_reg == 3'd4) begin
                    state_next = S_TDIV;
                end else begin
                    pp_next = pp_reg + 3'd1;
                end
            end
            S_TDIV: begin
                if (div_done) begin
                    if (div_q == 64'd0) begin
                        state_next = S_EXP;
                    end else begin
                        term_next = div_q;
                        sum_next  = sum_reg + div_q;
                        if (n_reg == TERM_N_W'(TERMS_MAX)) begin
                            state_next = S_EXP;
                        end else begin
                            n_next     = n_reg + TERM_N_W'(1);
                            pp_next    = '0;
                            acc_next   = '0;
                            state_next = S_TMUL;
                        end
                    end
                end
            end
            S_EXP: begin
                ex_next    = ex_calc;
                state_next = S_PMUL;
            end
            S_PMUL: begin
                state_next = S_PRND;
            end
            S_PRND: begin
                if (!out_hold) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        z_reg       <= z_next;
        price_reg   <= price_next;
        y_reg       <= y_next;
        kp_reg      <= kp_next;
        red_cnt_reg <= red_cnt_next;
        r_reg       <= r_next;
        term_reg    <= term_next;
        sum_reg     <= sum_next;
        n_reg       <= n_next;
        pp_reg      <= pp_next;
        acc_reg     <= acc_next;
        ex_reg      <= ex_next;
    end

    assign st.idle      = (state_reg == S_IDLE);
    assign st.res_valid = (state_reg == S_PRND) && !out_hold;

endmodule

// File: sv/gbm_path_step_top.sv
// ----------------------------------------------------------------------------
// gbm_path_step_top: one log-euler step of a geometric brownian motion path
// takes a normal sample per word and returns the updated q16.16 price
// ----------------------------------------------------------------------------
// Each input word carries one standard-normal sample z (signed q4.12). The
// block forms e = drift + diffusion*z in q4.28, saturates it to [-8, 8),
// computes exp(e) rounded to q8.24 and multiplies it into the running price,
// rounding to q16.16 and saturating (tuser flags the saturation). The price is
// reloaded from start_price at the first step of every path; tlast marks the
// step that closes a path of steps_per_path steps (0 counts as 1, values above
// MAX_STEPS count as MAX_STEPS). A step runs through the taylor terms of exp(r),
// r in [0, ln2), computed up to and including the first that truncates to zero
// (1 to 18 terms). Each term takes four 32x32 partial products on the one shared
// multiplier and a division by the term index in 16 iterations; the block
// accepts no new sample until the current one has reached the output register,
// but it takes the next sample while a finished word waits there, once the
// sequencer is back to idle.
// Configuration writes are only allowed while the block is idle.
module gbm_path_step_top import gps_pkg::*; #(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // sample stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,    // [15:0] z
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,    // [31:0] price, [44:32] step_index
    output logic                  m_tlast,    // path_end
    output logic [0:0]            m_tuser,    // [0] overflow
    // register writes
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // steps_per_path is 13 bits, so the effective cap never exceeds its max
    localparam int STEP_CAP = (MAX_STEPS < SPP_MAX) ? MAX_STEPS : SPP_MAX;
    localparam int STEP_W   = $clog2(STEP_CAP + 1);

    // configuration registers
    logic [PRICE_W-1:0] start_price_reg;
    logic [DRIFT_W-1:0] drift_reg;
    logic [DIFF_W-1:0]  diffusion_reg;
    logic [SPP_W-1:0]   spp_reg;

    // path state
    logic [PRICE_W-1:0] cur_price_reg, cur_price_next;
    logic [STEP_W-1:0]  step_cnt_reg, step_cnt_next;

    // output word register
    logic                  m_valid_reg, m_valid_next;
    logic [PRICE_W-1:0]    m_price_reg, m_price_next;
    logic [STEP_IDX_W-1:0] m_idx_reg, m_idx_next;
    logic                  m_last_reg, m_last_next;
    logic                  m_ovf_reg, m_ovf_next;

    logic              accept;
    logic              out_hold;
    logic [PRICE_W-1:0] price_in;
    logic [SPP_W-1:0]  limit;
    logic [STEP_W:0]   cnt_inc;
    logic              path_end;
    gps_coef_t         coef;
    gps_seq_st_t       seq_st;
    gps_res_t          seq_res;

    // register file, written by the user only while idle; the block has no check for it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_price_reg <= START_PRICE_RST;
            drift_reg       <= '0;
            diffusion_reg   <= '0;
            spp_reg         <= SPP_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_START_PRICE: start_price_reg <= cfg_wdata[PRICE_W-1:0];
                REG_DRIFT:       drift_reg       <= cfg_wdata[DRIFT_W-1:0];
                REG_DIFFUSION:   diffusion_reg   <= cfg_wdata[DIFF_W-1:0];
                REG_STEPS:       spp_reg         <= cfg_wdata[SPP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign coef.drift     = drift_reg;
    assign coef.diffusion = diffusion_reg;

    // handshake: ready whenever the sequencer is idle
    assign s_tready = seq_st.idle;
    assign accept   = s_tvalid && s_tready;
    assign out_hold = m_valid_reg && !m_tready;

    // a new path starts from the configured price
    assign price_in = (step_cnt_reg == '0) ? start_price_reg : cur_price_reg;

    gps_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (accept),
        .z        (signed'(s_tdata[Z_W-1:0])),
        .price_in (price_in),
        .coef     (coef),
        .out_hold (out_hold),
        .st       (seq_st),
        .res      (seq_res)
    );

    // effective path length: at least one step, at most the cap
    always_comb begin
        if (spp_reg == '0) begin
            limit = SPP_W'(1);
        end else if (spp_reg > SPP_W'(STEP_CAP)) begin
            limit = SPP_W'(STEP_CAP);
        end else begin
            limit = spp_reg;
        end
        cnt_inc  = {1'b0, step_cnt_reg} + (STEP_W+1)'(1);
        // a lowered length ends the path at the first step that reaches it
        path_end = ((SPP_W+1)'(cnt_inc) >= {1'b0, limit});
    end

    always_comb begin
        cur_price_next = cur_price_reg;
        step_cnt_next  = step_cnt_reg;
        m_valid_next   = m_valid_reg;
        m_price_next   = m_price_reg;
        m_idx_next     = m_idx_reg;
        m_last_next    = m_last_reg;
        m_ovf_next     = m_ovf_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            cur_price_next = price_in;
        end
        if (seq_st.res_valid) begin
            cur_price_next = seq_res.price;
            step_cnt_next  = path_end ? '0 : cnt_inc[STEP_W-1:0];
            m_valid_next   = 1'b1;
            m_price_next   = seq_res.price;
            m_idx_next     = STEP_IDX_W'(cnt_inc[STEP_W-1:0]);
            m_last_next    = path_end;
            m_ovf_next     = seq_res.ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_price_reg <= '0;
            step_cnt_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_price_reg <= cur_price_next;
            step_cnt_reg  <= step_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
        m_price_reg <= m_price_next;
        m_idx_reg   <= m_idx_next;
        m_last_reg  <= m_last_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {3'b000, m_idx_reg, m_price_reg};
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_ovf_reg;

endmodule

// File: sv/gps_checker.sv
// ----------------------------------------------------------------------------
// gps_checker: port-level checks of the gbm path step block
// bound to the top level
// ----------------------------------------------------------------------------
module gps_checker import gps_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [47:0]           m_tdata,
    input logic                  m_tlast,
    input logic [0:0]            m_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result word changed while stalled");

    // the block is not ready in the cycle after it accepts a sample
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample accepted while a step is in flight");

    // overflow only with a saturated price
    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[31:0] == 32'hFFFFFFFF)
        else $error("overflow flagged without saturated price");

    // step index counts from one
    a_idx_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[44:32] != 13'd0)
        else $error("zero step index");

    // reset leaves the block empty and ready
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not empty after reset");

endmodule

bind gbm_path_step_top gps_checker u_gps_checker (.*);
